// ===== rtl/mcp_pkg.sv =====
// Package for the midpoint circle plotter: item codes, register indexes,
// controller states and the command and status structs between the two halves.
// Depends on nothing.
package mcp_pkg;

  localparam int PIX_W     = 17;
  localparam int ADDR_W    = 32;
  localparam int COLOR_W   = 16;
  localparam int FIELD_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int LINE_W    = 16;
  localparam int BPP_W     = 6;
  localparam int IDX_W     = 3;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_VRAM_BASE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PIXELS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_PIXEL = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX = 3'd7;

  localparam logic [ADDR_W-1:0] VRAM_BASE_RESET      = 32'd0;
  localparam logic [LINE_W-1:0] LINE_PIXELS_RESET    = 16'd640;
  localparam logic [BPP_W-1:0]  BITS_PER_PIXEL_RESET = 6'd16;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             load;
    logic             clear_busy;
    logic             issue;
    logic [IDX_W-1:0] idx;
    logic             update;
  } cmd_t;

  typedef struct packed {
    logic step_ok;
    logic advance;
  } status_t;

endpackage

// ===== rtl/mcp_controller.sv =====
// Controller of the midpoint circle plotter: takes items and sequences the
// eight pixel writes of a step. Depends on mcp_pkg.
module mcp_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             func,
  input  mcp_pkg::status_t status,
  output mcp_pkg::cmd_t    cmd
);

  mcp_pkg::state_t state;
  mcp_pkg::state_t state_next;
  logic [mcp_pkg::IDX_W-1:0] cnt;
  logic [mcp_pkg::IDX_W-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcp_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    in_ready       = 1'b0;
    cmd.load       = 1'b0;
    cmd.clear_busy = 1'b0;
    cmd.issue      = 1'b0;
    cmd.idx        = cnt;
    cmd.update     = 1'b0;
    unique case (state)
      mcp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cnt_next = '0;
        if (in_valid) begin
          if (func == mcp_pkg::FUNC_START) begin
            cmd.load = 1'b1;
          end else if (status.step_ok) begin
            state_next = mcp_pkg::ST_EMIT;
          end else begin
            cmd.clear_busy = 1'b1;
          end
        end
      end
      mcp_pkg::ST_EMIT: begin
        if (status.advance) begin
          cmd.issue = 1'b1;
          cnt_next  = cnt + 1'b1;
          if (cnt == mcp_pkg::LAST_IDX) begin
            cmd.update = 1'b1;
            state_next = mcp_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = mcp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/mcp_datapath.sv =====
// Datapath of the midpoint circle plotter: circle state, configuration
// registers and the three-stage pixel and address pipeline. Depends on mcp_pkg.
module mcp_datapath #(
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [mcp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mcp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [mcp_pkg::FIELD_W-1:0]       center_x,
  input  logic [mcp_pkg::FIELD_W-1:0]       center_y,
  input  logic [mcp_pkg::FIELD_W-1:0]       radius,
  input  logic [mcp_pkg::COLOR_W-1:0]       color,
  input  mcp_pkg::cmd_t                     cmd,
  output mcp_pkg::status_t                  status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mcp_pkg::PIX_W-1:0]  pixel_x,
  output logic signed [mcp_pkg::PIX_W-1:0]  pixel_y,
  output logic [mcp_pkg::ADDR_W-1:0]        pixel_address,
  output logic [mcp_pkg::COLOR_W-1:0]       pixel_color,
  output logic                              last_of_step,
  output logic                              circle_done
);

  localparam int OW = COORD_BITS + 1;
  localparam int DW = COORD_BITS + 4;

  logic [mcp_pkg::ADDR_W-1:0] vram_base;
  logic [mcp_pkg::LINE_W-1:0] line_pixels;
  logic [mcp_pkg::BPP_W-1:0]  bits_per_pixel;

  logic signed [COORD_BITS-1:0] centre_col;
  logic signed [COORD_BITS-1:0] centre_row;
  logic signed [OW-1:0]         offset_w;
  logic signed [OW-1:0]         offset_h;
  logic signed [DW-1:0]         decision;
  logic [mcp_pkg::COLOR_W-1:0]  draw_color;
  logic                         busy;

  logic signed [COORD_BITS-1:0] r_in;
  logic signed [DW-1:0]         r_d;
  logic signed [DW-1:0]         w_d;
  logic signed [DW-1:0]         d1;
  logic signed [DW-1:0]         decision_next;
  logic signed [OW-1:0]         w_next;
  logic signed [OW-1:0]         h_next;
  logic                         done_next;

  logic signed [mcp_pkg::PIX_W-1:0] cx;
  logic signed [mcp_pkg::PIX_W-1:0] cy;
  logic signed [mcp_pkg::PIX_W-1:0] ew;
  logic signed [mcp_pkg::PIX_W-1:0] eh;
  logic signed [mcp_pkg::PIX_W-1:0] px;
  logic signed [mcp_pkg::PIX_W-1:0] py;

  logic                             advance;
  logic                             s1_valid;
  logic signed [mcp_pkg::PIX_W-1:0] s1_x;
  logic signed [mcp_pkg::PIX_W-1:0] s1_y;
  logic [mcp_pkg::COLOR_W-1:0]      s1_color;
  logic                             s1_last;
  logic                             s1_done;
  logic                             s2_valid;
  logic signed [mcp_pkg::PIX_W-1:0] s2_x;
  logic signed [mcp_pkg::PIX_W-1:0] s2_y;
  logic [mcp_pkg::ADDR_W-1:0]       s2_lin;
  logic [mcp_pkg::COLOR_W-1:0]      s2_color;
  logic                             s2_last;
  logic                             s2_done;
  logic [mcp_pkg::ADDR_W-1:0]       lin;
  logic [mcp_pkg::ADDR_W-1:0]       addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      vram_base      <= mcp_pkg::VRAM_BASE_RESET;
      line_pixels    <= mcp_pkg::LINE_PIXELS_RESET;
      bits_per_pixel <= mcp_pkg::BITS_PER_PIXEL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mcp_pkg::REG_VRAM_BASE:      vram_base      <= cfg_data;
        mcp_pkg::REG_LINE_PIXELS:    line_pixels    <= cfg_data[mcp_pkg::LINE_W-1:0];
        mcp_pkg::REG_BITS_PER_PIXEL: bits_per_pixel <= cfg_data[mcp_pkg::BPP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign r_in = signed'(radius[COORD_BITS-1:0]);
  assign r_d  = DW'(r_in);

  // Midpoint update of the octant point.
  always_comb begin
    w_d    = DW'(offset_w);
    w_next = offset_w;
    d1     = decision;
    if (!decision[DW-1]) begin
      w_next = offset_w - 1'b1;
      d1     = decision - ((w_d - 1'b1) <<< 2);
    end
    h_next        = offset_h + 1'b1;
    decision_next = d1 + (DW'(h_next) <<< 2) + DW'(2);
    done_next     = (w_next < h_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.load) begin
      busy <= !r_in[COORD_BITS-1];
    end else if (cmd.clear_busy) begin
      busy <= 1'b0;
    end else if (cmd.update && done_next) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      centre_col <= signed'(center_x[COORD_BITS-1:0]);
      centre_row <= signed'(center_y[COORD_BITS-1:0]);
      offset_w   <= OW'(r_in);
      offset_h   <= '0;
      decision   <= DW'(3) - (r_d <<< 1);
      draw_color <= color;
    end else if (cmd.update) begin
      offset_w <= w_next;
      offset_h <= h_next;
      decision <= decision_next;
    end
  end

  assign status.step_ok = busy && !(offset_w < offset_h);
  assign status.advance = advance;

  assign cx = mcp_pkg::PIX_W'(centre_col);
  assign cy = mcp_pkg::PIX_W'(centre_row);
  assign ew = mcp_pkg::PIX_W'(offset_w);
  assign eh = mcp_pkg::PIX_W'(offset_h);

  // The eight mirrored points of the current octant point.
  always_comb begin
    case (cmd.idx)
      3'd0:    begin px = cx + ew; py = cy + eh; end
      3'd1:    begin px = cx - ew; py = cy + eh; end
      3'd2:    begin px = cx + eh; py = cy + ew; end
      3'd3:    begin px = cx - eh; py = cy + ew; end
      3'd4:    begin px = cx - ew; py = cy - eh; end
      3'd5:    begin px = cx - eh; py = cy - ew; end
      3'd6:    begin px = cx + eh; py = cy - ew; end
      default: begin px = cx + ew; py = cy - eh; end
    endcase
  end

  assign advance = !out_valid || out_ready;

  assign lin = mcp_pkg::ADDR_W'(s1_x)
             + mcp_pkg::ADDR_W'(mcp_pkg::ADDR_W'(s1_y) * mcp_pkg::ADDR_W'(line_pixels));
  assign addr = vram_base + mcp_pkg::ADDR_W'(s2_lin * mcp_pkg::ADDR_W'(bits_per_pixel[5:3]));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= cmd.issue;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_x          <= px;
      s1_y          <= py;
      s1_color      <= draw_color;
      s1_last       <= cmd.update;
      s1_done       <= cmd.update && done_next;
      s2_x          <= s1_x;
      s2_y          <= s1_y;
      s2_lin        <= lin;
      s2_color      <= s1_color;
      s2_last       <= s1_last;
      s2_done       <= s1_done;
      pixel_x       <= s2_x;
      pixel_y       <= s2_y;
      pixel_address <= addr;
      pixel_color   <= s2_color;
      last_of_step  <= s2_last;
      circle_done   <= s2_done;
    end
  end

endmodule

// ===== rtl/midpoint_circle_plotter_core.sv =====
// Midpoint circle plotter: a start item loads a circle, each step item gives
// eight pixel writes. A start item, or a step with no circle left, gives no pixel
// write. A step item is accepted and then gives one pixel write a cycle through
// the address pipeline, unless the output stalls; each pixel passes the s1, s2 and
// output registers. Synchronous reset clears the controller, the pipeline valid bits
// and the circle, and loads the configuration registers with their reset values.
module midpoint_circle_plotter_core #(
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [mcp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mcp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              func,
  input  logic [mcp_pkg::FIELD_W-1:0]       center_x,
  input  logic [mcp_pkg::FIELD_W-1:0]       center_y,
  input  logic [mcp_pkg::FIELD_W-1:0]       radius,
  input  logic [mcp_pkg::COLOR_W-1:0]       color,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mcp_pkg::PIX_W-1:0]  pixel_x,
  output logic signed [mcp_pkg::PIX_W-1:0]  pixel_y,
  output logic [mcp_pkg::ADDR_W-1:0]        pixel_address,
  output logic [mcp_pkg::COLOR_W-1:0]       pixel_color,
  output logic                              last_of_step,
  output logic                              circle_done
);

  mcp_pkg::cmd_t    cmd;
  mcp_pkg::status_t status;

  mcp_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .status   (status),
    .cmd      (cmd)
  );

  mcp_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .center_x      (center_x),
    .center_y      (center_y),
    .radius        (radius),
    .color         (color),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .last_of_step  (last_of_step),
    .circle_done   (circle_done)
  );

endmodule
